### hdl/assert_macros.svh
// Assertion macros included by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHECK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/efd_pkg.sv
// Types and codes of the elevator floor dispatcher.
package efd_pkg;

   typedef logic [4:0] floor_type;
   typedef logic [1:0] dir_type;
   typedef logic [1:0] event_type;
   typedef logic [1:0] status_type;

   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_PASSED  = 1'b1;

   localparam dir_type DIR_STOP = 2'd0;
   localparam dir_type DIR_UP   = 2'd1;
   localparam dir_type DIR_DOWN = 2'd2;
   localparam dir_type DIR_BAD  = 2'd3;

   localparam status_type ST_FREE   = 2'd0;
   localparam status_type ST_TARGET = 2'd1;
   localparam status_type ST_BUSY   = 2'd2;

   localparam event_type EV_MOVE     = 2'd1;
   localparam event_type EV_CONTINUE = 2'd2;
   localparam event_type EV_IDLE     = 2'd3;

endpackage

### hdl/elevator_floor_dispatcher.sv
// An item that gives no result leaves busy low; otherwise the two-way floor scan runs, and
// runs again from the cabin floor when a request lands on that floor; the result strobe is
// registered from the final step of the scan.
// Throughput: one item at a time; busy stays high while the shared floor pointer walks the
// pending bitmap, one floor per cycle. Each result is strobed for one cycle, not stallable.
// Reset (synchronous): no pending floors, status free, cabin at floor 1, direction stopped.
module elevator_floor_dispatcher #(
   parameter int FLOORS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  efd_pkg::floor_type  req_floor,
   input  efd_pkg::dir_type    req_moving_direction,
   output logic                rsp_strobe,
   output efd_pkg::event_type  rsp_event_res,
   output efd_pkg::floor_type  rsp_current_floor,
   output efd_pkg::floor_type  rsp_target_floor
);
   import efd_pkg::*;

`include "assert_macros.svh"

   localparam int PW = ($clog2(FLOORS + 2) > 5) ? $clog2(FLOORS + 2) : 6;
   localparam int IW = $clog2(FLOORS);
   localparam logic [PW-1:0] FLOORS_P = PW'(FLOORS);
   localparam logic [PW-1:0] ONE_P = PW'(1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic              state_ff, state_in;
   logic              arr_ff, arr_in;
   logic              dn_ff, dn_in;
   logic              second_ff, second_in;
   logic [PW-1:0]     ptr_ff, ptr_in;
   floor_type         req_floor_ff, req_floor_in;
   logic [FLOORS-1:0] pending_ff, pending_in;
   status_type        status_ff, status_in;
   floor_type         cabin_ff, cabin_in;
   dir_type           dir_ff, dir_in;
   floor_type         goal_ff, goal_in;
   logic              rsp_valid_ff, rsp_valid_in;
   event_type         rsp_event_ff, rsp_event_in;
   floor_type         rsp_cur_ff, rsp_cur_in;
   floor_type         rsp_tgt_ff, rsp_tgt_in;

   logic              accept;
   logic [PW-1:0]     req_ext;
   logic [PW-1:0]     req_m1;
   logic              req_in_range;
   logic [PW-1:0]     cabin_ext;
   logic [PW-1:0]     cabin_m1;
   logic [PW-1:0]     ptr_m1;
   logic              ptr_in_range;
   logic              hit;
   floor_type         pick;
   dir_type           new_dir;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign req_ext = {{(PW-5){1'b0}}, req_floor};
   assign req_m1 = req_ext - ONE_P;
   assign req_in_range = (req_ext >= ONE_P) && (req_ext <= FLOORS_P);
   assign cabin_ext = {{(PW-5){1'b0}}, cabin_ff};
   assign cabin_m1 = cabin_ext - ONE_P;
   assign ptr_m1 = ptr_ff - ONE_P;
   assign ptr_in_range = (ptr_ff >= ONE_P) && (ptr_ff <= FLOORS_P);
   assign hit = ptr_in_range && pending_ff[ptr_m1[IW-1:0]];
   // Found floors are always real requests, so they fit the five-bit field.
   assign pick = hit ? ptr_ff[4:0] : req_floor_ff;
   assign new_dir = (req_moving_direction == DIR_BAD) ? DIR_STOP : req_moving_direction;

   always_comb begin
      state_in     = state_ff;
      arr_in       = arr_ff;
      dn_in        = dn_ff;
      second_in    = second_ff;
      ptr_in       = ptr_ff;
      req_floor_in = req_floor_ff;
      pending_in   = pending_ff;
      status_in    = status_ff;
      cabin_in     = cabin_ff;
      dir_in       = dir_ff;
      goal_in      = goal_ff;
      rsp_valid_in = 1'b0;
      rsp_event_in = rsp_event_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_in_range) begin
               if (req_action == ACT_REQUEST) begin
                  pending_in[req_m1[IW-1:0]] = 1'b1;
                  req_floor_in = req_floor;
                  if (status_ff != ST_TARGET) begin
                     status_in = ST_TARGET;
                     ptr_in    = cabin_ext;
                     dn_in     = (dir_ff != DIR_UP);
                     second_in = 1'b0;
                     arr_in    = 1'b0;
                     state_in  = S_SCAN;
                  end
               end else if (status_ff == ST_TARGET || status_ff == ST_BUSY) begin
                  status_in = ST_BUSY;
                  cabin_in  = req_floor;
                  dir_in    = new_dir;
                  if (req_floor == goal_ff) begin
                     // Arrived: drop this floor and look for the next goal.
                     pending_in[req_m1[IW-1:0]] = 1'b0;
                     ptr_in    = req_ext;
                     dn_in     = (new_dir != DIR_UP);
                     second_in = 1'b0;
                     arr_in    = 1'b1;
                     state_in  = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (hit || (!ptr_in_range && second_ff)) begin
               if (arr_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_cur_in   = cabin_ff;
                  state_in     = S_IDLE;
                  if (hit) begin
                     goal_in      = pick;
                     rsp_event_in = EV_CONTINUE;
                     rsp_tgt_in   = pick;
                  end else begin
                     status_in    = ST_FREE;
                     rsp_event_in = EV_IDLE;
                     rsp_tgt_in   = cabin_ff;
                  end
               end else begin
                  goal_in = pick;
                  if (pick == cabin_ff) begin
                     // The goal is where the cabin stands: handle the arrival now.
                     status_in = ST_BUSY;
                     pending_in[cabin_m1[IW-1:0]] = 1'b0;
                     ptr_in    = cabin_ext;
                     dn_in     = (dir_ff != DIR_UP);
                     second_in = 1'b0;
                     arr_in    = 1'b1;
                  end else begin
                     dir_in       = (pick > cabin_ff) ? DIR_UP : DIR_DOWN;
                     rsp_valid_in = 1'b1;
                     rsp_event_in = EV_MOVE;
                     rsp_cur_in   = cabin_ff;
                     rsp_tgt_in   = pick;
                     state_in     = S_IDLE;
                  end
               end
            end else if (!ptr_in_range) begin
               // First direction ran off the end: turn around at the cabin floor.
               ptr_in    = cabin_ext;
               dn_in     = !dn_ff;
               second_in = 1'b1;
            end else begin
               ptr_in = dn_ff ? (ptr_ff - ONE_P) : (ptr_ff + ONE_P);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= '0;
         status_ff    <= ST_FREE;
         cabin_ff     <= 5'd1;
         dir_ff       <= DIR_STOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         status_ff    <= status_in;
         cabin_ff     <= cabin_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arr_ff       <= arr_in;
      dn_ff        <= dn_in;
      second_ff    <= second_in;
      ptr_ff       <= ptr_in;
      req_floor_ff <= req_floor_in;
      goal_ff      <= goal_in;
      rsp_event_ff <= rsp_event_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_tgt_ff   <= rsp_tgt_in;
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_event_res     = rsp_event_ff;
   assign rsp_current_floor = rsp_cur_ff;
   assign rsp_target_floor  = rsp_tgt_ff;

   `CHECK_SAME(a_strobe_idle, rsp_strobe, !busy, "result strobed while still scanning")
   `CHECK_NEXT(a_single_pulse, rsp_strobe, !rsp_strobe, "back-to-back result strobes")
   `CHECK_SAME(a_move_elsewhere, rsp_strobe && rsp_event_res == EV_MOVE,
      rsp_target_floor != rsp_current_floor, "move event targets the cabin floor")
   `CHECK_SAME(a_idle_free, rsp_strobe && rsp_event_res == EV_IDLE,
      status_ff == ST_FREE && rsp_target_floor == rsp_current_floor,
      "idle event without free status")

endmodule
